// ----- src/b2b_pkg.sv -----
package b2b_pkg;

   localparam int B2B_WORD_W = 64;
   localparam int B2B_ROUNDS = 12;
   localparam int B2B_ROUNDS_MAX = 12;
   localparam logic [63:0] B2B_PARAM_RESET = 64'h0000_0000_0101_0040;

   typedef struct packed {
      logic       msg_wr;
      logic       first;
      logic       last;
      logic [3:0] wr_pos;
      logic       init;
      logic       step;
      logic [1:0] phase;
      logic [3:0] rd_row;
      logic [1:0] rd_phase;
      logic       fold;
      logic [2:0] emit_idx;
   } b2b_cmd_type;

   function automatic logic [63:0] iv_word(input logic [2:0] idx);
      logic [63:0] w;
      unique case (idx)
         3'd0: w = 64'h6A09E667F3BCC908;
         3'd1: w = 64'hBB67AE8584CAA73B;
         3'd2: w = 64'h3C6EF372FE94F82B;
         3'd3: w = 64'hA54FF53A5F1D36F1;
         3'd4: w = 64'h510E527FADE682D1;
         3'd5: w = 64'h9B05688C2B3E6C1F;
         3'd6: w = 64'h1F83D9ABFB41BD6B;
         3'd7: w = 64'h5BE0CD19137E2179;
      endcase
      return w;
   endfunction

   // One schedule row packed as sixteen nibbles, slot 0 in the top nibble.
   function automatic logic [63:0] sched_row(input logic [3:0] row);
      logic [63:0] r;
      unique case (row)
         4'd0:    r = 64'h0123456789ABCDEF;
         4'd1:    r = 64'hEA489FD61C02B753;
         4'd2:    r = 64'hB8C052FDAE367194;
         4'd3:    r = 64'h7931DCBE265A40F8;
         4'd4:    r = 64'h905724AFE1BC683D;
         4'd5:    r = 64'h2C6A0B834D75FE19;
         4'd6:    r = 64'hC51FED4A0763928B;
         4'd7:    r = 64'hDB7EC13950F4862A;
         4'd8:    r = 64'h6FE9B308C2D714A5;
         4'd9:    r = 64'hA2847615FB9E3CD0;
         default: r = 64'h0123456789ABCDEF;
      endcase
      return r;
   endfunction

endpackage

// ----- src/b2b_req_if.sv -----
interface b2b_req_if import b2b_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [B2B_WORD_W-1:0] msg_word;
   logic [B2B_WORD_W-1:0] byte_count;
   logic                  final_block;
   logic                  chain_start;

   modport source(output valid, output msg_word, output byte_count,
                  output final_block, output chain_start, input ready);
   modport sink(input valid, input msg_word, input byte_count,
                input final_block, input chain_start, output ready);
endinterface

// ----- src/b2b_rsp_if.sv -----
interface b2b_rsp_if import b2b_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [B2B_WORD_W-1:0] hash_word;
   logic                  word_last;

   modport source(output valid, output hash_word, output word_last, input ready);
   modport sink(input valid, input hash_word, input word_last, output ready);
endinterface

// ----- src/b2b_ctrl.sv -----
module b2b_ctrl import b2b_pkg::*; #(
   parameter int ROUNDS = B2B_ROUNDS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output b2b_cmd_type cmd
);

   localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam logic [RW-1:0] RND_LAST = RW'(ROUNDS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_FOLD  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [3:0]    pos_ff, pos_in;
   logic [3:0]    row_ff, row_in;
   logic [1:0]    phase_ff, phase_in;
   logic [RW-1:0] rnd_ff, rnd_in;
   logic [2:0]    idx_ff, idx_in;
   logic          req_xfer;
   logic          rsp_xfer;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      row_in   = row_ff;
      phase_in = phase_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;

      cmd          = '0;
      cmd.msg_wr   = req_xfer;
      cmd.first    = (pos_ff == 4'd0);
      cmd.last     = (pos_ff == 4'd15);
      cmd.wr_pos   = pos_ff;
      cmd.phase    = phase_ff;
      cmd.emit_idx = idx_ff;
      // prefetch the message words of the following half step
      if (phase_ff == 2'd3) begin
         cmd.rd_row   = (row_ff == 4'd9) ? 4'd0 : row_ff + 4'd1;
         cmd.rd_phase = 2'd0;
      end else begin
         cmd.rd_row   = row_ff;
         cmd.rd_phase = phase_ff + 2'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               pos_in = pos_ff + 4'd1;
               if (pos_ff == 4'd15) state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init     = 1'b1;
            cmd.rd_row   = 4'd0;
            cmd.rd_phase = 2'd0;
            row_in       = 4'd0;
            phase_in     = 2'd0;
            rnd_in       = '0;
            state_in     = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.step = 1'b1;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               row_in = (row_ff == 4'd9) ? 4'd0 : row_ff + 4'd1;
               rnd_in = rnd_ff + 1'b1;
               if (rnd_ff == RND_LAST) state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            idx_in   = 3'd0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= 4'd0;
         row_ff   <= 4'd0;
         phase_ff <= 2'd0;
         rnd_ff   <= '0;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         row_ff   <= row_in;
         phase_ff <= phase_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ----- src/b2b_datapath.sv -----
module b2b_datapath import b2b_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  b2b_cmd_type           cmd,
   input  logic                  csr_wr_en,
   input  logic [B2B_WORD_W-1:0] csr_wr_data,
   input  logic [B2B_WORD_W-1:0] msg_word,
   input  logic [B2B_WORD_W-1:0] byte_count,
   input  logic                  final_block,
   input  logic                  chain_start,
   output logic [B2B_WORD_W-1:0] hash_word,
   output logic                  word_last
);

   logic [63:0] mem_a_ff [16];
   logic [63:0] mem_b_ff [16];
   logic [63:0] msg_ff   [4];
   logic [3:0]  rd_addr  [4];
   logic [63:0] row_bits;

   logic [63:0] v_ff     [16];
   logic [63:0] v_in     [16];
   logic [63:0] chain_ff [8];
   logic [63:0] chain_in [8];
   logic [63:0] param_ff, param_in;
   logic [63:0] cnt_ff, cnt_in;
   logic        fin_ff, fin_in;

   logic [63:0] g_a [4];
   logic [63:0] g_b [4];
   logic [63:0] g_c [4];
   logic [63:0] g_d [4];

   logic diag;
   logic half;

   assign diag = cmd.phase[1];
   assign half = cmd.phase[0];

   // slot of lane l is diag*8 + 2*l + half
   always_comb begin
      logic [3:0] slot;
      row_bits = sched_row(cmd.rd_row);
      for (int l = 0; l < 4; l++) begin
         slot       = {cmd.rd_phase[1], 2'(l), cmd.rd_phase[0]};
         rd_addr[l] = row_bits[{~slot, 2'b00} +: 4];
      end
   end

   // two copies of the block buffer give four read ports
   always_ff @(posedge clock) begin
      if (cmd.msg_wr) begin
         mem_a_ff[cmd.wr_pos] <= msg_word;
         mem_b_ff[cmd.wr_pos] <= msg_word;
      end
      msg_ff[0] <= mem_a_ff[rd_addr[0]];
      msg_ff[1] <= mem_a_ff[rd_addr[1]];
      msg_ff[2] <= mem_b_ff[rd_addr[2]];
      msg_ff[3] <= mem_b_ff[rd_addr[3]];
   end

   for (genvar gl = 0; gl < 4; gl++) begin : g_lane
      localparam int BC = 4 + gl;
      localparam int CC = 8 + gl;
      localparam int DC = 12 + gl;
      localparam int BD = 4 + ((gl + 1) % 4);
      localparam int CD = 8 + ((gl + 2) % 4);
      localparam int DD = 12 + ((gl + 3) % 4);

      logic [63:0] a0, b0, c0, d0;
      logic [63:0] a1, c1, t1, t2;

      assign a0 = v_ff[gl];
      assign b0 = diag ? v_ff[BD] : v_ff[BC];
      assign c0 = diag ? v_ff[CD] : v_ff[CC];
      assign d0 = diag ? v_ff[DD] : v_ff[DC];

      assign a1 = a0 + b0 + msg_ff[gl];
      assign t1 = d0 ^ a1;
      assign g_d[gl] = half ? {t1[15:0], t1[63:16]} : {t1[31:0], t1[63:32]};
      assign c1 = c0 + g_d[gl];
      assign t2 = b0 ^ c1;
      assign g_b[gl] = half ? {t2[62:0], t2[63]} : {t2[23:0], t2[63:24]};
      assign g_a[gl] = a1;
      assign g_c[gl] = c1;
   end

   always_comb begin
      v_in = v_ff;
      if (cmd.init) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i]     = chain_ff[i];
            v_in[i + 8] = iv_word(3'(i));
         end
         v_in[12] = iv_word(3'd4) ^ cnt_ff;
         v_in[14] = iv_word(3'd6) ^ {64{fin_ff}};
      end else if (cmd.step) begin
         for (int l = 0; l < 4; l++) begin
            v_in[l] = g_a[l];
            if (diag) begin
               v_in[4 + ((l + 1) & 3)]  = g_b[l];
               v_in[8 + ((l + 2) & 3)]  = g_c[l];
               v_in[12 + ((l + 3) & 3)] = g_d[l];
            end else begin
               v_in[4 + l]  = g_b[l];
               v_in[8 + l]  = g_c[l];
               v_in[12 + l] = g_d[l];
            end
         end
      end
   end

   always_comb begin
      chain_in = chain_ff;
      param_in = csr_wr_en ? csr_wr_data : param_ff;
      cnt_in   = cnt_ff;
      fin_in   = fin_ff;
      if (cmd.msg_wr && cmd.first && chain_start) begin
         for (int i = 0; i < 8; i++) chain_in[i] = iv_word(3'(i));
         chain_in[0] = iv_word(3'd0) ^ param_ff;
      end
      if (cmd.msg_wr && cmd.last) begin
         cnt_in = byte_count;
         fin_in = final_block;
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] ^ v_ff[i] ^ v_ff[i + 8];
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      cnt_ff <= cnt_in;
      fin_ff <= fin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= iv_word(3'(i));
         param_ff <= B2B_PARAM_RESET;
      end else begin
         chain_ff <= chain_in;
         param_ff <= param_in;
      end
   end

   assign hash_word = chain_ff[cmd.emit_idx];
   assign word_last = (cmd.emit_idx == 3'd7);

endmodule

// ----- src/blake2b_compression.sv -----
// Flow: after the sixteenth word is taken the control steps through INIT, the rounds and FOLD
// before the first result word, then one result word a cycle while the sink is ready.
// Blocks: a new block is taken only after all eight result words have left; four
// G lanes each do one half of a mix per cycle, so a round runs the column mixes, then the diagonal.
// Reset: synchronous, active high; loads the IV into the chain and the default
// parameter word, clears the control; the block buffer and work vector stay unset.
module blake2b_compression import b2b_pkg::*; #(
   parameter int ROUNDS = B2B_ROUNDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [B2B_WORD_W-1:0] csr_wr_data,
   b2b_req_if.sink               req_chan,
   b2b_rsp_if.source             rsp_chan
);

   b2b_cmd_type cmd;

   b2b_ctrl #(
      .ROUNDS(ROUNDS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .cmd      (cmd)
   );

   b2b_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .msg_word   (req_chan.msg_word),
      .byte_count (req_chan.byte_count),
      .final_block(req_chan.final_block),
      .chain_start(req_chan.chain_start),
      .hash_word  (rsp_chan.hash_word),
      .word_last  (rsp_chan.word_last)
   );

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rsp_chan.valid)
      else $error("input taken while results are pending");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.word_last |=> !rsp_chan.valid)
      else $error("results continue past the marked word");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_chan.ready && !rsp_chan.valid)
      else $error("block not ready after reset");
`endif

endmodule
